[sv/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the IRQ counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Check the consequent in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

[sv/pmic_pkg.sv]
// Types and constants of the prescaled multi-source IRQ counter.
package pmic_pkg;

  typedef enum logic [1:0] {
    EVT_CPU_CYCLE = 2'd0,
    EVT_PPU_CYCLE = 2'd1,
    EVT_CPU_WRITE = 2'd2,
    EVT_PPU_READ  = 2'd3
  } evt_e;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd1,
    REG_DISABLE   = 3'd2,
    REG_ENABLE    = 3'd3,
    REG_PRE_LOAD  = 3'd4,
    REG_MAIN_LOAD = 3'd5,
    REG_KEY       = 3'd6
  } reg_e;

  localparam logic [1:0] DIR_DOWN = 2'b10;
  localparam logic [1:0] DIR_UP   = 2'b01;

  localparam logic [3:0] CTRL_BLOCK  = 4'hC;
  localparam logic [7:0] EDGE_NARROW = 8'h07;
  localparam logic [7:0] EDGE_WIDE   = 8'hFF;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  typedef struct packed {
    logic              enabled;
    logic [7:0]        mode;
    logic [DATA_W-1:0] prescaler;
    logic [DATA_W-1:0] main_cnt;
    logic [DATA_W-1:0] key;
    logic              last_a12;
    logic              irq;
  } state_t;

endpackage

[sv/prescaled_multisource_irq_counter.sv]
// Top level of the prescaled multi-source IRQ counter.
// One bus event request is taken every clock when not stalled; its result (IRQ
// line, prescaler, main counter after the event) appears on the master side in
// the next cycle from a result register. The counter state register feeds back
// through a single pass of step logic, so back-to-back events need no gaps;
// the slave stalls only while a finished result is held by master backpressure.
`include "assert_macros.svh"

module prescaled_multisource_irq_counter import pmic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // address[15:0], data[23:16]
  input  logic [1:0]           s_axis_tuser,  // event kind[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // irq_pending[0], count_low[8:1],
                                              // count_high[16:9], zero[23:17]
);

  state_t            state_q;
  state_t            state_d;
  logic              s_fire;
  logic              out_valid_q;
  logic              out_valid_d;
  logic [16:0]       out_data_q;
  logic [16:0]       out_data_d;
  evt_e              kind;

  assign kind          = evt_e'(s_axis_tuser);
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  pmic_step u_step (
    .state_i   (state_q),
    .kind_i    (kind),
    .address_i (s_axis_tdata[ADDR_W-1:0]),
    .data_i    (s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .state_o   (state_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = {state_d.main_cnt, state_d.prescaler, state_d.irq};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s_fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(M_TDATA_W-17){1'b0}}, out_data_q};

  `ASSERT_NEXT(a_fire_gives_result, s_fire, m_axis_tvalid)
  `ASSERT_NEXT(a_idle_holds_state, !s_fire, $stable(state_q))
  `ASSERT_NEXT(a_disabled_no_count,
               s_fire && !state_q.enabled && kind != EVT_CPU_WRITE,
               $stable(state_q.prescaler) && $stable(state_q.main_cnt))
  `ASSERT_SAME(a_result_matches_state, m_axis_tvalid,
               out_data_q == {state_q.main_cnt, state_q.prescaler, state_q.irq})

endmodule

[sv/pmic_step.sv]
// Next-state logic of the IRQ counter for one bus event.
module pmic_step import pmic_pkg::*; (
  input  state_t            state_i,
  input  evt_e              kind_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [DATA_W-1:0] data_i,
  output state_t            state_o
);

  logic              selected;
  logic              a12;
  logic              tick;
  logic [DATA_W-1:0] edge_mask;
  logic [DATA_W-1:0] pre_dn;
  logic [DATA_W-1:0] pre_up;
  logic [DATA_W-1:0] main_dn;
  logic [DATA_W-1:0] main_up;
  state_t            clk_st;
  state_t            nxt;

  assign selected  = state_i.enabled && (state_i.mode[1:0] == kind_i);
  assign a12       = address_i[12];
  assign edge_mask = state_i.mode[2] ? EDGE_NARROW : EDGE_WIDE;
  assign pre_dn    = state_i.prescaler - 8'd1;
  assign pre_up    = state_i.prescaler + 8'd1;
  assign main_dn   = state_i.main_cnt - 8'd1;
  assign main_up   = state_i.main_cnt + 8'd1;

  always_comb begin
    if (kind_i == EVT_PPU_CYCLE) begin
      tick = selected && !state_i.last_a12 && a12;
    end else begin
      tick = selected;
    end
  end

  // Track A12; on a tick step the prescaler, and at its edge the main counter.
  always_comb begin
    clk_st = state_i;
    if (kind_i == EVT_PPU_CYCLE && selected) begin
      clk_st.last_a12 = a12;
    end
    if (tick) begin
      case (state_i.mode[7:6])
        DIR_DOWN: begin
          clk_st.prescaler = pre_dn;
          if ((pre_dn & edge_mask) == edge_mask) begin
            clk_st.main_cnt = main_dn;
            if (main_dn == 8'hFF) begin
              clk_st.irq = 1'b1;
            end
          end
        end
        DIR_UP: begin
          clk_st.prescaler = pre_up;
          if ((pre_up & edge_mask) == 8'd0) begin
            clk_st.main_cnt = main_up;
            if (main_up == 8'd0) begin
              clk_st.irq = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Apply the register write after the count.
  always_comb begin
    nxt = clk_st;
    if (kind_i == EVT_CPU_WRITE && address_i[15:12] == CTRL_BLOCK) begin
      unique case (reg_e'(address_i[2:0]))
        REG_MODE:      nxt.mode = data_i;
        REG_DISABLE: begin
          nxt.enabled = 1'b0;
          nxt.irq     = 1'b0;
        end
        REG_ENABLE:    nxt.enabled   = 1'b1;
        REG_PRE_LOAD:  nxt.prescaler = data_i ^ state_i.key;
        REG_MAIN_LOAD: nxt.main_cnt  = data_i ^ state_i.key;
        REG_KEY:       nxt.key       = data_i;
        default: begin
        end
      endcase
    end
  end

  assign state_o = nxt;

endmodule
